// ----- hw/rtl/cpr_pkg.sv -----
// Shared types, widths, register map and status codes of the channel packet reassembler.
// No dependencies; every other file of the block imports this package.
package cpr_pkg;

	// Field widths of the header beat and of the result beat
	localparam int unsigned ADDR_W   = 32;
	localparam int unsigned CNT_W    = 32;
	localparam int unsigned CHAN_W   = 16;
	localparam int unsigned IDX_W    = 16;
	localparam int unsigned PLEN_W   = 16;
	localparam int unsigned SIZE_W   = 24;
	localparam int unsigned STATUS_W = 2;

	// Default header sizes in bytes
	localparam int unsigned PKT_HDR_BYTES  = 44;
	localparam int unsigned CHAN_HDR_BYTES = 16;
	localparam int unsigned CHAN_END_BYTES = 4;

	// Configuration port
	localparam int unsigned PADDR_W = 4;
	localparam int unsigned PDATA_W = 32;

	typedef enum logic [1:0] {
		REG_CHANNEL     = 2'd0,
		REG_FILTER_EN   = 2'd1,
		REG_EXPECT_ADDR = 2'd2
	} reg_idx_t;

	localparam logic [CHAN_W-1:0] CHANNEL_RESET = 16'd8;

	typedef enum logic [STATUS_W-1:0] {
		ST_COPIED    = 2'd0,
		ST_IGNORED   = 2'd1,
		ST_OVERFLOW  = 2'd2,
		ST_MALFORMED = 2'd3
	} status_t;

	typedef struct packed {
		logic [CHAN_W-1:0] channel_of_interest;
		logic              source_filter_enable;
		logic [ADDR_W-1:0] expected_source_addr;
	} cfg_t;

	typedef struct packed {
		logic [ADDR_W-1:0] source_addr;
		logic [CNT_W-1:0]  packet_counter;
		logic [CHAN_W-1:0] channel_id;
		logic [IDX_W-1:0]  index_in_channel;
		logic [IDX_W-1:0]  packets_in_channel;
		logic [SIZE_W-1:0] total_length;
		logic [PLEN_W-1:0] packet_length;
	} item_t;

	typedef struct packed {
		status_t           status;
		logic              counter_gap;
		logic [PLEN_W-1:0] copy_start;
		logic [PLEN_W-1:0] copy_length;
		logic [SIZE_W-1:0] write_offset;
		logic              channel_done;
		logic [SIZE_W-1:0] channel_size;
	} result_t;

	typedef struct packed {
		logic [CNT_W-1:0]  last_counter;
		logic              last_counter_valid;
		logic              synced;
		logic [SIZE_W-1:0] buffer_size;
		logic [SIZE_W-1:0] fill_position;
	} state_t;

endpackage

// ----- hw/rtl/cpr_regs.sv -----
// APB-style configuration registers of the channel packet reassembler.
// Depends on cpr_pkg for the register map and the configuration struct.
module cpr_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [cpr_pkg::PADDR_W-1:0]   paddr,
	input  logic [cpr_pkg::PDATA_W-1:0]   pwdata,
	output logic [cpr_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	output cpr_pkg::cfg_t                 cfg
);
	import cpr_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Write on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.channel_of_interest  <= CHANNEL_RESET;
			cfg_q.source_filter_enable <= 1'b0;
			cfg_q.expected_source_addr <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_CHANNEL:     cfg_q.channel_of_interest  <= pwdata[CHAN_W-1:0];
				REG_FILTER_EN:   cfg_q.source_filter_enable <= pwdata[0];
				REG_EXPECT_ADDR: cfg_q.expected_source_addr <= pwdata[ADDR_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		prdata = '0;
		case (idx)
			REG_CHANNEL:     prdata = PDATA_W'(cfg_q.channel_of_interest);
			REG_FILTER_EN:   prdata = PDATA_W'(cfg_q.source_filter_enable);
			REG_EXPECT_ADDR: prdata = PDATA_W'(cfg_q.expected_source_addr);
			default:         prdata = '0;
		endcase
	end

endmodule

// ----- hw/rtl/cpr_step.sv -----
// Per-beat decision logic: sequence check, channel filter, header strip and fit check.
// Depends on cpr_pkg for the beat, result, state and configuration structs.
module cpr_step #(
	parameter int unsigned PACKET_HEADER_BYTES  = cpr_pkg::PKT_HDR_BYTES,
	parameter int unsigned CHANNEL_HEADER_BYTES = cpr_pkg::CHAN_HDR_BYTES,
	parameter int unsigned CHANNEL_END_BYTES    = cpr_pkg::CHAN_END_BYTES
) (
	input  cpr_pkg::item_t   item,
	input  cpr_pkg::state_t  st,
	input  cpr_pkg::cfg_t    cfg,
	output cpr_pkg::result_t res,
	output cpr_pkg::state_t  nxt
);
	import cpr_pkg::*;

	// Header byte counts are held in 17 bits; parameter values beyond that are truncated
	localparam int unsigned HW = PLEN_W + 1;
	localparam logic [HW-1:0] START_MID   = HW'(PACKET_HEADER_BYTES);
	localparam logic [HW-1:0] START_FIRST = HW'(PACKET_HEADER_BYTES + CHANNEL_HEADER_BYTES);
	localparam logic [HW-1:0] END_BYTES   = HW'(CHANNEL_END_BYTES);

	logic              first;
	logic              last;
	logic [HW-1:0]     start;
	logic [HW-1:0]     need;
	logic [PLEN_W-1:0] len;
	logic [SIZE_W:0]   fill_sum;
	logic [CNT_W-1:0]  cnt_step;
	logic              filtered;

	always_comb begin
		first    = (item.index_in_channel == '0);
		last     = (({1'b0, item.index_in_channel} + HW'(1)) == {1'b0, item.packets_in_channel});
		start    = first ? START_FIRST : START_MID;
		need     = start + (last ? END_BYTES : '0);
		len      = item.packet_length - need[PLEN_W-1:0];
		cnt_step = item.packet_counter - st.last_counter;
		filtered = cfg.source_filter_enable &&
			(item.source_addr != cfg.expected_source_addr);

		res        = '0;
		res.status = ST_IGNORED;
		nxt        = st;
		fill_sum   = '0;

		if (!filtered) begin
			// Sequence check: any step other than one drops sync
			if (st.last_counter_valid && (cnt_step != CNT_W'(1))) begin
				res.counter_gap = 1'b1;
				nxt.synced      = 1'b0;
			end
			nxt.last_counter       = item.packet_counter;
			nxt.last_counter_valid = 1'b1;

			if (item.channel_id == cfg.channel_of_interest) begin
				// Index zero syncs and latches the buffer size once
				if (first) begin
					nxt.synced        = 1'b1;
					nxt.fill_position = '0;
					if (st.buffer_size == '0) begin
						nxt.buffer_size = item.total_length;
					end
				end
				fill_sum = {1'b0, nxt.fill_position} + (SIZE_W + 1)'(len);

				if (nxt.synced) begin
					if ({1'b0, item.packet_length} < need) begin
						res.status = ST_MALFORMED;
					end else if (fill_sum > {1'b0, nxt.buffer_size}) begin
						res.status = ST_OVERFLOW;
					end else begin
						res.status        = ST_COPIED;
						res.copy_start    = start[PLEN_W-1:0];
						res.copy_length   = len;
						res.write_offset  = nxt.fill_position;
						nxt.fill_position = fill_sum[SIZE_W-1:0];
					end
					// Completion clears all state
					if (last) begin
						res.channel_done = 1'b1;
						res.channel_size = nxt.fill_position;
						nxt              = '0;
					end
				end
			end
		end
	end

endmodule

// ----- hw/rtl/channel_packet_reassembler.sv -----
// Path: a header beat accepted into the input register passes the state update, then the
// result register, before its result beat is valid; one beat per cycle sustained while
// out_ready keeps the result register free.
// An input register and a result register part the two sides, so one header is still
// taken while a result waits. Reset (arst_n low, asynchronous) clears the sequence and
// channel state and sets the registers to channel 8, filter off, expected address 0.
module channel_packet_reassembler #(
	parameter int unsigned PACKET_HEADER_BYTES  = cpr_pkg::PKT_HDR_BYTES,
	parameter int unsigned CHANNEL_HEADER_BYTES = cpr_pkg::CHAN_HDR_BYTES,
	parameter int unsigned CHANNEL_END_BYTES    = cpr_pkg::CHAN_END_BYTES
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Configuration port
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [cpr_pkg::PADDR_W-1:0]    paddr,
	input  logic [cpr_pkg::PDATA_W-1:0]    pwdata,
	output logic [cpr_pkg::PDATA_W-1:0]    prdata,
	output logic                           pready,
	// Header beats
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [cpr_pkg::ADDR_W-1:0]     source_addr,
	input  logic [cpr_pkg::CNT_W-1:0]      packet_counter,
	input  logic [cpr_pkg::CHAN_W-1:0]     channel_id,
	input  logic [cpr_pkg::IDX_W-1:0]      index_in_channel,
	input  logic [cpr_pkg::IDX_W-1:0]      packets_in_channel,
	input  logic [cpr_pkg::SIZE_W-1:0]     total_length,
	input  logic [cpr_pkg::PLEN_W-1:0]     packet_length,
	// Result beats
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [cpr_pkg::STATUS_W-1:0]   status,
	output logic                           counter_gap,
	output logic [cpr_pkg::PLEN_W-1:0]     copy_start,
	output logic [cpr_pkg::PLEN_W-1:0]     copy_length,
	output logic [cpr_pkg::SIZE_W-1:0]     write_offset,
	output logic                           channel_done,
	output logic [cpr_pkg::SIZE_W-1:0]     channel_size
);
	import cpr_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_s2;
	logic    valid_s2;
	state_t  st_q;
	result_t res;
	state_t  nxt;
	logic    advance;
	logic    fire_s1;

	cpr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	cpr_step #(
		.PACKET_HEADER_BYTES  (PACKET_HEADER_BYTES),
		.CHANNEL_HEADER_BYTES (CHANNEL_HEADER_BYTES),
		.CHANNEL_END_BYTES    (CHANNEL_END_BYTES)
	) u_step (
		.item (item_s1),
		.st   (st_q),
		.cfg  (cfg),
		.res  (res),
		.nxt  (nxt)
	);

	// Flow control: the result register frees when empty or taken
	assign advance  = !valid_s2 || out_ready;
	assign fire_s1  = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.source_addr        <= source_addr;
			item_s1.packet_counter     <= packet_counter;
			item_s1.channel_id         <= channel_id;
			item_s1.index_in_channel   <= index_in_channel;
			item_s1.packets_in_channel <= packets_in_channel;
			item_s1.total_length       <= total_length;
			item_s1.packet_length      <= packet_length;
		end
	end

	// Reassembly state: advance once per processed beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (fire_s1) begin
			st_q <= nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			res_s2 <= res;
		end
	end

	assign out_valid    = valid_s2;
	assign status       = res_s2.status;
	assign counter_gap  = res_s2.counter_gap;
	assign copy_start   = res_s2.copy_start;
	assign copy_length  = res_s2.copy_length;
	assign write_offset = res_s2.write_offset;
	assign channel_done = res_s2.channel_done;
	assign channel_size = res_s2.channel_size;

endmodule

// ----- hw/rtl/cpr_checker.sv -----
// Port-level checks of the channel packet reassembler, bound to the top level.
// Depends on cpr_pkg for status codes and field widths.
module cpr_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         pready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [cpr_pkg::STATUS_W-1:0] status,
	input logic [cpr_pkg::PLEN_W-1:0]   copy_start,
	input logic [cpr_pkg::PLEN_W-1:0]   copy_length,
	input logic [cpr_pkg::SIZE_W-1:0]   write_offset,
	input logic                         channel_done,
	input logic [cpr_pkg::SIZE_W-1:0]   channel_size
);
	import cpr_pkg::*;

	// Stalled result beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(channel_size))
		else $error("result beat changed while stalled");

	// Nothing to copy unless the beat was copied
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_COPIED) |->
			(copy_start == '0) && (copy_length == '0) && (write_offset == '0))
		else $error("copy fields set on a beat that was not copied");

	// Channel size only reported on completion
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !channel_done |-> (channel_size == '0))
		else $error("channel size reported without completion");

	// Completion only comes from a packet of the channel of interest
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && channel_done |-> (status != ST_IGNORED))
		else $error("completion on an ignored packet");

	// Configuration port never stalls
	assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("configuration port stalled");

endmodule

bind channel_packet_reassembler cpr_checker u_cpr_checker (.*);

// ----- dv/channel_packet_reassembler_checker.sv -----
// Checker for the channel packet reassembler: mirrors the register writes, predicts one
// copy descriptor per header beat and compares result beats in order. Depends on cpr_pkg.
`timescale 1ns / 1ps

module channel_packet_reassembler_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic                           pready,
	input  logic [cpr_pkg::PADDR_W-1:0]    paddr,
	input  logic [cpr_pkg::PDATA_W-1:0]    pwdata,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  logic [cpr_pkg::ADDR_W-1:0]     source_addr,
	input  logic [cpr_pkg::CNT_W-1:0]      packet_counter,
	input  logic [cpr_pkg::CHAN_W-1:0]     channel_id,
	input  logic [cpr_pkg::IDX_W-1:0]      index_in_channel,
	input  logic [cpr_pkg::IDX_W-1:0]      packets_in_channel,
	input  logic [cpr_pkg::SIZE_W-1:0]     total_length,
	input  logic [cpr_pkg::PLEN_W-1:0]     packet_length,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  logic [cpr_pkg::STATUS_W-1:0]   status,
	input  logic                           counter_gap,
	input  logic [cpr_pkg::PLEN_W-1:0]     copy_start,
	input  logic [cpr_pkg::PLEN_W-1:0]     copy_length,
	input  logic [cpr_pkg::SIZE_W-1:0]     write_offset,
	input  logic                           channel_done,
	input  logic [cpr_pkg::SIZE_W-1:0]     channel_size,
	output int                             fail_count,
	output int                             pending
);
	import cpr_pkg::*;

	cfg_t    cfg_mirror;
	state_t  reasm_st;
	result_t descr_q[$];
	result_t descr_exp;
	item_t   hdr_seen;

	// Work out the copy descriptor of one header and advance the reassembly state
	function automatic result_t reassemble_header(input item_t h);
		result_t     r;
		logic        first;
		logic        last;
		int unsigned start;
		int unsigned need;
		int unsigned len;
		r = '0;
		r.status = ST_IGNORED;
		if (!(cfg_mirror.source_filter_enable &&
				h.source_addr != cfg_mirror.expected_source_addr)) begin
			// any counter step other than one drops sync
			if (reasm_st.last_counter_valid &&
					(h.packet_counter - reasm_st.last_counter) != 32'd1) begin
				r.counter_gap = 1'b1;
				reasm_st.synced = 1'b0;
			end
			reasm_st.last_counter = h.packet_counter;
			reasm_st.last_counter_valid = 1'b1;
			if (h.channel_id == cfg_mirror.channel_of_interest) begin
				first = (h.index_in_channel == '0);
				// last-packet test in 17 bits so that index 0xFFFF never wraps onto zero
				last = ({1'b0, h.index_in_channel} + 17'd1) == {1'b0, h.packets_in_channel};
				if (first) begin
					reasm_st.synced = 1'b1;
					if (reasm_st.buffer_size == '0)
						reasm_st.buffer_size = h.total_length;
					reasm_st.fill_position = '0;
				end
				if (reasm_st.synced) begin
					start = PKT_HDR_BYTES + (first ? CHAN_HDR_BYTES : 0);
					need = start + (last ? CHAN_END_BYTES : 0);
					if (h.packet_length < need) begin
						r.status = ST_MALFORMED;
					end else begin
						len = h.packet_length - need;
						if (reasm_st.fill_position + len > reasm_st.buffer_size) begin
							r.status = ST_OVERFLOW;
						end else begin
							r.status = ST_COPIED;
							r.copy_start = start[PLEN_W-1:0];
							r.copy_length = len[PLEN_W-1:0];
							r.write_offset = reasm_st.fill_position;
							reasm_st.fill_position = reasm_st.fill_position + len[SIZE_W-1:0];
						end
					end
					// completion reports the fill and starts afresh
					if (last) begin
						r.channel_done = 1'b1;
						r.channel_size = reasm_st.fill_position;
						reasm_st = '0;
					end
				end
			end
		end
		return r;
	endfunction

	task automatic check_field(input string fname, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
				$time, fname, want, got);
			fail_count++;
		end
	endtask

	// Mirror register writes, check result beats, then predict from header beats
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_mirror = '{channel_of_interest: CHANNEL_RESET,
				source_filter_enable: 1'b0, expected_source_addr: '0};
			reasm_st = '0;
			descr_q.delete();
			pending = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[PADDR_W-1:2]))
					REG_CHANNEL: begin
						cfg_mirror.channel_of_interest = pwdata[CHAN_W-1:0];
					end
					REG_FILTER_EN: begin
						cfg_mirror.source_filter_enable = pwdata[0];
					end
					REG_EXPECT_ADDR: begin
						cfg_mirror.expected_source_addr = pwdata[ADDR_W-1:0];
					end
					default: begin
					end
				endcase
			end
			if (out_valid && out_ready) begin
				if (descr_q.size() == 0) begin
					$display("%0t: result beat with no header pending, expected none, got status 0x%0h",
						$time, status);
					fail_count++;
				end else begin
					descr_exp = descr_q.pop_front();
					check_field("status", descr_exp.status, status);
					check_field("counter_gap", descr_exp.counter_gap, counter_gap);
					check_field("copy_start", descr_exp.copy_start, copy_start);
					check_field("copy_length", descr_exp.copy_length, copy_length);
					check_field("write_offset", descr_exp.write_offset, write_offset);
					check_field("channel_done", descr_exp.channel_done, channel_done);
					check_field("channel_size", descr_exp.channel_size, channel_size);
				end
			end
			if (in_valid && in_ready) begin
				hdr_seen.source_addr = source_addr;
				hdr_seen.packet_counter = packet_counter;
				hdr_seen.channel_id = channel_id;
				hdr_seen.index_in_channel = index_in_channel;
				hdr_seen.packets_in_channel = packets_in_channel;
				hdr_seen.total_length = total_length;
				hdr_seen.packet_length = packet_length;
				descr_q.push_back(reassemble_header(hdr_seen));
			end
			pending = descr_q.size();
		end
	end

endmodule

// ----- dv/channel_packet_reassembler_test.sv -----
// Top of the channel packet reassembler testbench: clock, reset, register writes, header
// stimulus and the verdict. Depends on cpr_pkg, the block and the checker module.
`timescale 1ns / 1ps

module channel_packet_reassembler_test;
	import cpr_pkg::*;

	localparam int STALL_LIMIT = 3000;
	localparam int HOLD_CYCLES = 150;
	localparam int PHASE_ITEMS = 110;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [PADDR_W-1:0]    paddr;
	logic [PDATA_W-1:0]    pwdata;
	logic [PDATA_W-1:0]    prdata;
	logic                  pready;
	logic                  in_valid;
	logic                  in_ready;
	item_t                 tx_hdr;
	logic                  out_valid;
	logic                  out_ready;
	logic [STATUS_W-1:0]   status;
	logic                  counter_gap;
	logic [PLEN_W-1:0]     copy_start;
	logic [PLEN_W-1:0]     copy_length;
	logic [SIZE_W-1:0]     write_offset;
	logic                  channel_done;
	logic [SIZE_W-1:0]     channel_size;

	int          fail_count;
	int          pending;
	int          stall_cycles;
	int          send_idle_pct;
	int          recv_stall_pct;
	bit          hold_req;
	int unsigned hdr_count;
	logic [31:0] tx_cnt;
	logic [15:0] cfg_chan;
	logic        cfg_filter;
	logic [31:0] cfg_addr;

	channel_packet_reassembler u_top (
		.clk                (clk),
		.arst_n             (arst_n),
		.psel               (psel),
		.penable            (penable),
		.pwrite             (pwrite),
		.paddr              (paddr),
		.pwdata             (pwdata),
		.prdata             (prdata),
		.pready             (pready),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.source_addr        (tx_hdr.source_addr),
		.packet_counter     (tx_hdr.packet_counter),
		.channel_id         (tx_hdr.channel_id),
		.index_in_channel   (tx_hdr.index_in_channel),
		.packets_in_channel (tx_hdr.packets_in_channel),
		.total_length       (tx_hdr.total_length),
		.packet_length      (tx_hdr.packet_length),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.status             (status),
		.counter_gap        (counter_gap),
		.copy_start         (copy_start),
		.copy_length        (copy_length),
		.write_offset       (write_offset),
		.channel_done       (channel_done),
		.channel_size       (channel_size)
	);

	channel_packet_reassembler_checker u_checker (
		.clk                (clk),
		.arst_n             (arst_n),
		.psel               (psel),
		.penable            (penable),
		.pwrite             (pwrite),
		.pready             (pready),
		.paddr              (paddr),
		.pwdata             (pwdata),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.source_addr        (tx_hdr.source_addr),
		.packet_counter     (tx_hdr.packet_counter),
		.channel_id         (tx_hdr.channel_id),
		.index_in_channel   (tx_hdr.index_in_channel),
		.packets_in_channel (tx_hdr.packets_in_channel),
		.total_length       (tx_hdr.total_length),
		.packet_length      (tx_hdr.packet_length),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.status             (status),
		.counter_gap        (counter_gap),
		.copy_start         (copy_start),
		.copy_length        (copy_length),
		.write_offset       (write_offset),
		.channel_done       (channel_done),
		.channel_size       (channel_size),
		.fail_count         (fail_count),
		.pending            (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// End the run when nothing has moved for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("FAIL channel_packet_reassembler");
			$finish;
		end
	end

	// Result side: random stalls, plus one long hold-off on request
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			out_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Offer one header beat, idling first as the phase asks; returns at the accepting edge
	task automatic push_header(input item_t h);
		@(negedge clk);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		tx_hdr <= h;
		do @(posedge clk); while (!in_ready);
		hdr_count++;
	endtask

	task automatic send_fields(input logic [31:0] src, input logic [31:0] cnt,
			input logic [15:0] chan, input logic [15:0] idx, input logic [15:0] npk,
			input logic [23:0] total, input logic [15:0] plen);
		item_t h;
		h = '{source_addr: src, packet_counter: cnt, channel_id: chan,
			index_in_channel: idx, packets_in_channel: npk, total_length: total,
			packet_length: plen};
		push_header(h);
	endtask

	task automatic write_reg(input reg_idx_t r, input logic [31:0] v);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {r, 2'b00};
		pwdata <= v;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (r)
			REG_CHANNEL: cfg_chan = v[15:0];
			REG_FILTER_EN: cfg_filter = v[0];
			REG_EXPECT_ADDR: cfg_addr = v;
			default: begin
			end
		endcase
	endtask

	// Drain the block, then load new register values and idling rates
	task automatic begin_phase(input logic [15:0] chan, input logic filt,
			input logic [31:0] addr, input int s_pct, input int r_pct);
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		write_reg(REG_CHANNEL, {16'd0, chan});
		write_reg(REG_FILTER_EN, {31'd0, filt});
		write_reg(REG_EXPECT_ADDR, addr);
		send_idle_pct = s_pct;
		recv_stall_pct = r_pct;
	endtask

	// Stray traffic: random headers, other channels, foreign senders, counter slips
	task automatic send_noise();
		item_t h;
		h = '{source_addr: $urandom, packet_counter: $urandom, channel_id: $urandom,
			index_in_channel: $urandom, packets_in_channel: $urandom,
			total_length: $urandom, packet_length: $urandom};
		case ($urandom_range(4))
			0: push_header(h);
			1: begin
				if (h.channel_id == cfg_chan)
					h.channel_id = ~cfg_chan;
				if (cfg_filter)
					h.source_addr = cfg_addr;
				h.packet_counter = tx_cnt;
				tx_cnt++;
				push_header(h);
			end
			2: begin
				h.source_addr = cfg_addr ^ ($urandom | 32'd1);
				h.channel_id = cfg_chan;
				push_header(h);
			end
			3: begin
				// slip the counter forwards, or repeat the last one
				tx_cnt = $urandom_range(1) ? tx_cnt + $urandom_range(2, 1000) : tx_cnt - 1;
			end
			default: begin
				// our channel with random framing
				if (cfg_filter)
					h.source_addr = cfg_addr;
				h.channel_id = cfg_chan;
				h.packet_counter = tx_cnt;
				tx_cnt++;
				if ($urandom_range(2) == 0)
					h.index_in_channel = '0;
				if ($urandom_range(3) == 0)
					h.packets_in_channel = h.index_in_channel + 16'd1;
				push_header(h);
			end
		endcase
	endtask

	// One channel of consecutive packets, with the odd stray beat or short packet
	task automatic send_channel();
		int unsigned n;
		int unsigned sum;
		int unsigned total;
		int unsigned need;
		int unsigned dlen [0:31];
		item_t       h;
		n = ($urandom_range(9) == 0) ? $urandom_range(6, 24) : $urandom_range(1, 5);
		sum = 0;
		for (int unsigned i = 0; i < n; i++) begin
			dlen[i] = ($urandom_range(15) == 0) ? $urandom_range(0, 9000)
				: $urandom_range(0, 300);
			sum += dlen[i];
		end
		case ($urandom_range(9))
			0: total = (sum > 0) ? $urandom_range(0, sum - 1) : 0;
			1: total = 0;
			default: total = sum + $urandom_range(0, 64);
		endcase
		for (int unsigned i = 0; i < n; i++) begin
			if ($urandom_range(11) == 0)
				send_noise();
			need = PKT_HDR_BYTES + ((i == 0) ? CHAN_HDR_BYTES : 0)
				+ ((i == n - 1) ? CHAN_END_BYTES : 0);
			h.source_addr = cfg_filter ? cfg_addr : $urandom;
			h.packet_counter = tx_cnt;
			h.channel_id = cfg_chan;
			h.index_in_channel = i[15:0];
			h.packets_in_channel = n[15:0];
			h.total_length = total[23:0];
			h.packet_length = ($urandom_range(24) == 0) ? $urandom_range(0, need - 1)
				: need + dlen[i];
			tx_cnt++;
			push_header(h);
		end
	endtask

	task automatic run_random(input int unsigned count);
		int unsigned stop_at;
		stop_at = hdr_count + count;
		tx_cnt = ($urandom_range(3) == 0) ? 32'hFFFF_FFF8 - $urandom_range(0, 8) : $urandom;
		while (hdr_count < stop_at) begin
			if ($urandom_range(9) < 8)
				send_channel();
			else
				send_noise();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		tx_hdr = '0;
		stall_cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_req = 1'b0;
		hdr_count = 0;
		tx_cnt = '0;
		cfg_chan = CHANNEL_RESET;
		cfg_filter = 1'b0;
		cfg_addr = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset values: sync, copy, counter gap, short and overfull packets, wrap
		begin_phase(CHANNEL_RESET, 1'b0, 32'd0, 0, 0);
		send_fields(32'd0, 32'd0, 16'd0, 16'd0, 16'd0, 24'd0, 16'd0);
		send_fields(32'd0, 32'd1, 16'd8, 16'd0, 16'd3, 24'd1000, 16'd160);
		send_fields(32'd0, 32'd2, 16'd8, 16'd1, 16'd3, 24'd1000, 16'd44);
		send_fields(32'd0, 32'd3, 16'd8, 16'd2, 16'd3, 24'd1000, 16'd98);
		send_fields(32'd0, 32'd5, 16'd8, 16'd1, 16'd3, 24'd1000, 16'd100);
		send_fields(32'd0, 32'd6, 16'd8, 16'd0, 16'd1, 24'd20, 16'd84);
		send_fields(32'd0, 32'd7, 16'd8, 16'd0, 16'd1, 24'd20, 16'd63);
		send_fields(32'd0, 32'd8, 16'd8, 16'd0, 16'd2, 24'd10, 16'd71);
		send_fields(32'd0, 32'd9, 16'd8, 16'd1, 16'd2, 24'd10, 16'd3);
		send_fields(32'd0, 32'd10, 16'd8, 16'd0, 16'd0, 24'd0, 16'd60);
		send_fields(32'd0, 32'd11, 16'd8, 16'd1, 16'd0, 24'd0, 16'd45);
		send_fields(32'd0, 32'd12, 16'd8, 16'd0, 16'd0, 24'd500, 16'hFFFF);
		send_fields(32'd0, 32'hFFFF_FFFF, 16'd8, 16'hFFFF, 16'hFFFF, 24'd0, 16'd100);
		send_fields(32'd0, 32'd0, 16'd8, 16'd0, 16'hFFFF, 24'hFF_FFFF, 16'hFFFF);
		send_fields(32'hFFFF_FFFF, 32'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFF_FFFF,
			16'hFFFF);
		send_fields(32'd0, 32'd2, 16'd8, 16'hFFFF, 16'd0, 24'd0, 16'd100);
		send_fields(32'd0, 32'd3, 16'd8, 16'hFFFE, 16'hFFFF, 24'd0, 16'hFFFF);

		// Source filter on: foreign senders leave the state alone
		begin_phase(16'hFFFF, 1'b1, 32'hFFFF_FFFF, 0, 0);
		send_fields(32'd0, 32'h1234_5678, 16'hFFFF, 16'd0, 16'd1, 24'd0, 16'd100);
		send_fields(32'hFFFF_FFFF, 32'd100, 16'hFFFF, 16'd0, 16'd2, 24'd300, 16'd160);
		send_fields(32'h7FFF_FFFF, 32'd5, 16'hFFFF, 16'd1, 16'd2, 24'd300, 16'd248);
		send_fields(32'hFFFF_FFFF, 32'd101, 16'hFFFF, 16'd1, 16'd2, 24'd300, 16'd248);
		send_fields(32'hFFFF_FFFF, 32'd102, 16'd8, 16'd0, 16'd1, 24'd300, 16'd64);

		// Random traffic under several register settings and idling patterns
		begin_phase($urandom, 1'b0, $urandom, 0, 0);
		hold_req = 1'b1;
		run_random(PHASE_ITEMS);
		begin_phase(16'd0, 1'b1, 32'd0, 65, 0);
		run_random(PHASE_ITEMS);
		begin_phase(16'hFFFF, 1'b1, 32'hFFFF_FFFF, 0, 65);
		run_random(PHASE_ITEMS);
		begin_phase($urandom, 1'b1, $urandom, 19, 19);
		run_random(PHASE_ITEMS);
		begin_phase(CHANNEL_RESET, 1'b0, 32'd0, 0, 0);
		run_random(PHASE_ITEMS);

		// Drain, then allow for anything trailing out of the pipeline
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		if (fail_count == 0)
			$display("PASS channel_packet_reassembler");
		else
			$display("FAIL channel_packet_reassembler");
		$finish;
	end

endmodule

// ----- channel_packet_reassembler.f -----
hw/rtl/cpr_pkg.sv
hw/rtl/cpr_regs.sv
hw/rtl/cpr_step.sv
hw/rtl/channel_packet_reassembler.sv
hw/rtl/cpr_checker.sv
dv/channel_packet_reassembler_checker.sv
dv/channel_packet_reassembler_test.sv
